// ----- rtl/crs_pkg.sv -----
// shared types, constants and helpers for the crash retry scheduler
package crs_pkg;

  localparam int TableEntriesDef = 16;
  localparam int BudgetDepthDef  = 16;
  localparam int TimeW           = 48;
  localparam int SlotW           = 32;
  localparam logic [TimeW-1:0] DenyDelayMs = 48'd2000;
  localparam logic [3:0] AttemptMax = 4'd15;

  typedef enum logic [2:0] {
    ACT_CRASH   = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_RETRY   = 3'd2,
    ACT_CANCEL  = 3'd3,
    ACT_OUTCOME = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    KIND_DONE      = 3'd0,
    KIND_RESPAWN   = 3'd1,
    KIND_GIVE_UP   = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_TICK_DONE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_GRACE    = 3'd0,
    REG_LIMIT    = 3'd1,
    REG_BACK1    = 3'd2,
    REG_BACK2    = 3'd3,
    REG_BACK3    = 3'd4,
    REG_BUDGET   = 3'd5,
    REG_WINDOW   = 3'd6,
    REG_ENABLE   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_SCAN,
    ST_EXPIRE,
    ST_DECIDE,
    ST_EMIT,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic search_clear;
    logic search_step;
    logic apply;
    logic scan_clear;
    logic scan_next;
    logic expire_pop;
    logic deny;
    logic allow;
    logic emit_entry;
    logic emit_final;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_done;
    logic is_tick;
    logic scan_done;
    logic cur_due;
    logic expire_needed;
    logic over_budget;
    logic out_busy;
  } status_t;

  // saturating time add
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] t,
                                              input logic [TimeW-1:0] d);
    logic [TimeW:0] s;
    s = {1'b0, t} + {1'b0, d};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

// ----- rtl/crs_ctrl.sv -----
// controller state machine for the crash retry scheduler
module crs_ctrl import crs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.search_clear = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.is_tick) begin
          cmd.scan_clear = 1'b1;
          state_next = ST_SCAN;
        end else if (sts.search_done) begin
          state_next = ST_APPLY;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_APPLY: begin
        if (!sts.out_busy) begin
          cmd.apply = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_FINISH;
        end else if (sts.cur_due) begin
          state_next = ST_EXPIRE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_EXPIRE: begin
        if (sts.expire_needed) cmd.expire_pop = 1'b1;
        else state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.over_budget) begin
          cmd.deny = 1'b1;
          cmd.scan_next = 1'b1;
          state_next = ST_SCAN;
        end else if (!sts.out_busy) begin
          // allow loads the result fields, so the previous beat must be gone
          cmd.allow = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit_entry = 1'b1;
          cmd.scan_next = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.emit_final = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/crs_datapath.sv -----
// table, budget ring and result register of the crash retry scheduler
module crs_datapath import crs_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int BUDGET_DEPTH  = BudgetDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_tvalid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_take,
  input  logic [2:0]  in_action,
  input  logic [SlotW-1:0] in_slot,
  input  logic [TimeW-1:0] in_now,
  input  logic        in_immediate,
  input  logic        in_ok,
  input  cmd_t        cmd,
  output status_t     sts,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int BIdxW = (BUDGET_DEPTH > 1) ? $clog2(BUDGET_DEPTH) : 1;
  localparam int BCntW = $clog2(BUDGET_DEPTH + 1);
  localparam int OutCntW = (CntW > 5) ? CntW : 5;

  // configuration
  logic [19:0] grace_ms, back1_ms, back2_ms, back3_ms;
  logic [3:0]  attempt_limit;
  logic [4:0]  attempt_budget;
  logic [31:0] window_ms;
  logic        respawn_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      grace_ms <= 20'd1000; attempt_limit <= 4'd3;
      back1_ms <= 20'd1000; back2_ms <= 20'd2000; back3_ms <= 20'd4000;
      attempt_budget <= 5'd8; window_ms <= 32'd10000; respawn_enable <= 1'b1;
    end else if (cfg_tvalid) begin
      case (reg_idx_t'(cfg_index))
        REG_GRACE:  grace_ms <= cfg_data[19:0];
        REG_LIMIT:  attempt_limit <= cfg_data[3:0];
        REG_BACK1:  back1_ms <= cfg_data[19:0];
        REG_BACK2:  back2_ms <= cfg_data[19:0];
        REG_BACK3:  back3_ms <= cfg_data[19:0];
        REG_BUDGET: attempt_budget <= cfg_data[4:0];
        REG_WINDOW: window_ms <= cfg_data;
        REG_ENABLE: respawn_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // held input item
  logic [2:0]       act;
  logic [SlotW-1:0] slot;
  logic [TimeW-1:0] now;
  logic             immediate, ok;
  always_ff @(posedge clk) begin
    if (in_take) begin
      act <= in_action; slot <= in_slot; now <= in_now;
      immediate <= in_immediate; ok <= in_ok;
    end
  end

  // table
  logic [TABLE_ENTRIES-1:0] valid, pending;
  logic [SlotW-1:0] ent_slot [TABLE_ENTRIES];
  logic [TimeW-1:0] ent_time [TABLE_ENTRIES];
  logic [3:0]       ent_att  [TABLE_ENTRIES];
  logic [CntW-1:0]  count;

  // budget ring
  logic [TimeW-1:0] times [BUDGET_DEPTH];
  logic [BIdxW-1:0] head;
  logic [BCntW-1:0] tcount;

  // search state: one entry a cycle
  logic [CntW-1:0] sidx;
  logic            found, free_found;
  logic [IdxW-1:0] hit, free_idx;
  logic [IdxW-1:0] sidx_i;
  assign sidx_i = sidx[IdxW-1:0];
  assign sts.search_done = (sidx == CntW'(TABLE_ENTRIES));
  assign sts.is_tick = (act == ACT_TICK);

  always_ff @(posedge clk) begin
    if (cmd.search_clear) begin
      sidx <= '0; found <= 1'b0; free_found <= 1'b0;
    end else if (cmd.search_step) begin
      sidx <= sidx + 1'b1;
      if (valid[sidx_i] && ent_slot[sidx_i] == slot && !found) begin
        found <= 1'b1; hit <= sidx_i;
      end
      if (!valid[sidx_i] && !free_found) begin
        free_found <= 1'b1; free_idx <= sidx_i;
      end
    end else if (cmd.scan_clear) begin
      sidx <= '0;
    end else if (cmd.scan_next) begin
      sidx <= sidx + 1'b1;
    end
  end

  // scan decisions; due snapshot taken at tick start
  logic [TABLE_ENTRIES-1:0] due;
  logic trip;
  logic [BCntW-1:0] budget;
  logic [TimeW:0] exp_sum;
  assign budget = (32'(attempt_budget) > 32'(BUDGET_DEPTH)) ? BCntW'(BUDGET_DEPTH)
                                                           : BCntW'(attempt_budget);
  assign sts.scan_done = sts.search_done;
  assign sts.cur_due = due[sidx_i] && respawn_enable;
  assign exp_sum = {1'b0, times[head]} + {17'd0, window_ms};
  assign sts.expire_needed = (tcount != '0) && (exp_sum <= {1'b0, now});
  assign sts.over_budget = (tcount >= budget);

  logic [3:0] att_inc;
  assign att_inc = (ent_att[sidx_i] < AttemptMax) ? ent_att[sidx_i] + 4'd1 : AttemptMax;

  logic [TimeW-1:0] backoff;
  always_comb begin
    if (ent_att[hit] >= 4'd3) backoff = TimeW'(back3_ms);
    else if (ent_att[hit] == 4'd2) backoff = TimeW'(back2_ms);
    else backoff = TimeW'(back1_ms);
  end

  logic [BIdxW:0] tail_sum;
  logic [BIdxW-1:0] tail;
  always_comb begin
    tail_sum = {1'b0, head} + (BIdxW+1)'(tcount);
    if (tail_sum >= (BIdxW+1)'(BUDGET_DEPTH)) tail_sum = tail_sum - (BIdxW+1)'(BUDGET_DEPTH);
    tail = tail_sum[BIdxW-1:0];
  end

  // output register
  logic [2:0]       o_kind;
  logic [SlotW-1:0] o_slot;
  logic [3:0]       o_att;
  logic             o_trip, o_last;
  logic [CntW-1:0]  o_count;
  assign sts.out_busy = m_tvalid && !m_tready;

  logic gone;
  assign gone = (att_inc > attempt_limit);

  // result fields of a non-tick item
  logic [2:0]      ap_kind;
  logic [3:0]      ap_att;
  logic [CntW-1:0] ap_count;
  always_comb begin
    ap_kind = KIND_DONE;
    ap_att = '0;
    ap_count = count;
    case (act)
      ACT_CRASH: begin
        if (found) ap_att = ent_att[hit];
        else if (free_found) ap_count = count + 1'b1;
        else ap_kind = KIND_FULL;
      end
      ACT_RETRY: if (found) ap_att = ent_att[hit];
      ACT_CANCEL: if (found) ap_count = count - 1'b1;
      ACT_OUTCOME: if (found) begin
        if (ok) ap_count = count - 1'b1;
        else ap_att = ent_att[hit];
      end
      default: if (found) ap_att = ent_att[hit];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0; pending <= '0; count <= '0;
      head <= '0; tcount <= '0; m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit_entry || cmd.emit_final || cmd.apply) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.scan_clear) begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          due[i] <= valid[i] && pending[i] && (now >= ent_time[i]);
        trip <= 1'b0;
      end
      if (cmd.expire_pop) begin
        head <= (head == BIdxW'(BUDGET_DEPTH - 1)) ? '0 : head + 1'b1;
        tcount <= tcount - 1'b1;
      end
      if (cmd.deny) begin
        ent_time[sidx_i] <= sat_add(now, DenyDelayMs);
        trip <= 1'b1;
      end
      if (cmd.allow) begin
        times[tail] <= now;
        tcount <= tcount + 1'b1;
        ent_att[sidx_i] <= att_inc;
        pending[sidx_i] <= 1'b0;
        if (gone) begin
          valid[sidx_i] <= 1'b0;
          count <= count - 1'b1;
        end
        o_kind <= gone ? KIND_GIVE_UP : KIND_RESPAWN;
        o_slot <= ent_slot[sidx_i];
        o_att <= att_inc;
      end
      if (cmd.emit_entry) begin
        o_trip <= 1'b0; o_last <= 1'b0; o_count <= count;
      end
      if (cmd.emit_final) begin
        o_kind <= KIND_TICK_DONE; o_slot <= '0; o_att <= '0;
        o_trip <= trip; o_last <= 1'b1; o_count <= count;
      end
      if (cmd.apply) begin
        o_kind <= ap_kind; o_slot <= slot; o_att <= ap_att;
        o_trip <= 1'b0; o_last <= 1'b1; o_count <= ap_count;
        case (act)
          ACT_CRASH: begin
            if (found) begin
              ent_time[hit] <= sat_add(now, TimeW'(grace_ms));
              pending[hit] <= 1'b1;
            end else if (free_found) begin
              valid[free_idx] <= 1'b1; pending[free_idx] <= 1'b1;
              ent_slot[free_idx] <= slot; ent_att[free_idx] <= '0;
              ent_time[free_idx] <= sat_add(now, TimeW'(grace_ms));
              count <= count + 1'b1;
            end
          end
          ACT_RETRY: if (found) begin
            if (immediate) ent_time[hit] <= '0;
            pending[hit] <= 1'b1;
          end
          ACT_CANCEL: if (found) begin
            valid[hit] <= 1'b0; pending[hit] <= 1'b0;
            count <= count - 1'b1;
          end
          ACT_OUTCOME: if (found) begin
            if (ok) begin
              valid[hit] <= 1'b0; pending[hit] <= 1'b0;
              count <= count - 1'b1;
            end else begin
              ent_time[hit] <= sat_add(now, backoff);
              pending[hit] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  logic [OutCntW-1:0] o_count_w;
  assign o_count_w = OutCntW'(o_count);
  assign m_tuser = o_kind;
  assign m_tlast = o_last;
  assign m_tdata = {6'd0, o_count_w[4:0], o_trip, o_att, o_slot};

endmodule

// ----- rtl/crash_retry_scheduler.sv -----
// top level of the crash retry scheduler
//
// channel  direction  tdata / payload                         tuser    tlast
// s_axis   in         slot_id, now_ms, immediate, ok          action   -
// m_axis   out        out_slot_id, attempt_number, trip, cnt  kind     last
// cfg      in         index 3 bits, data 32 bits              -        -
//
// a non-tick item first runs the slot search, which walks the table one entry a
// cycle; a tick scans every entry, with expire and decide for each due entry and
// emit for each allowed one. one item is in work at a time.
// reset is synchronous and clears the table valid flags and the budget ring.
// a stalled result holds the controller before it loads the next result.
module crash_retry_scheduler import crs_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int BUDGET_DEPTH  = BudgetDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot_id[31:0], now_ms[79:32], immediate[80], outcome_ok[81]
  input  logic [87:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_slot_id[31:0], attempt_number[35:32], breaker_tripped[36],
  // entry_count[41:37]
  output logic [47:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;
  logic    busy, take;

  assign s_axis_tready = !busy;
  assign take = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  crs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(take), .busy(busy), .sts(sts), .cmd(cmd)
  );

  crs_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .BUDGET_DEPTH(BUDGET_DEPTH)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_tvalid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_take(take),
    .in_action(s_axis_tuser),
    .in_slot(s_axis_tdata[31:0]),
    .in_now(s_axis_tdata[79:32]),
    .in_immediate(s_axis_tdata[80]),
    .in_ok(s_axis_tdata[81]),
    .cmd(cmd), .sts(sts),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser), .m_tlast(m_axis_tlast)
  );

endmodule

// ----- tb/sv/crash_retry_scheduler_checker.sv -----
// checker for the crash retry scheduler: predicts and compares result beats
`timescale 1ns / 1ps
module crash_retry_scheduler_checker import crs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_results,
  output int          result_total,
  output int          respawn_total,
  output int          giveup_total,
  output int          trip_total
);

  localparam logic [47:0] TMax = {48{1'b1}};
  localparam int ExpDepth = 64;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] slot;
    logic [3:0]  att;
    logic        trip;
    logic [4:0]  cnt;
    logic        last;
  } sched_result_t;

  // expected beats, oldest at exp_rd
  sched_result_t exp_mem [ExpDepth];
  int            exp_wr, exp_rd;

  logic [19:0] grace, back1, back2, back3;
  logic [3:0]  limit;
  logic [4:0]  budget;
  logic [31:0] window;
  logic        enable;

  logic        ent_valid [16];
  logic [31:0] ent_slot [16];
  logic        ent_pend [16];
  logic [47:0] ent_time [16];
  logic [3:0]  ent_att [16];
  logic [47:0] ring [16];
  int          ring_head, ring_cnt;

  function automatic logic [47:0] add_sat(logic [47:0] t, logic [47:0] d);
    logic [48:0] s;
    s = {1'b0, t} + {1'b0, d};
    return s[48] ? TMax : s[47:0];
  endfunction

  function automatic logic [4:0] occupied();
    int n;
    n = 0;
    for (int i = 0; i < 16; i++) if (ent_valid[i]) n++;
    return n[4:0];
  endfunction

  function automatic void put_result(kind_t k, logic [31:0] s, logic [3:0] a,
                                     logic t, logic l);
    sched_result_t r;
    r.kind = k; r.slot = s; r.att = a; r.trip = t; r.cnt = occupied(); r.last = l;
    exp_mem[exp_wr % ExpDepth] = r;
    exp_wr++;
  endfunction

  task automatic schedule_step(logic [2:0] a, logic [87:0] d);
    logic [2:0]  act;
    logic [31:0] id;
    logic [47:0] now;
    logic        imm, ok, trip;
    logic        due [16];
    int          e, lim;
    logic [47:0] dl;
    act = a; id = d[31:0]; now = d[79:32]; imm = d[80]; ok = d[81];
    e = -1; trip = 0;
    for (int i = 0; i < 16; i++)
      if (e < 0 && ent_valid[i] && ent_slot[i] == id) e = i;
    case (act)
      ACT_CRASH: begin
        if (e < 0) begin
          for (int i = 0; i < 16; i++) if (e < 0 && !ent_valid[i]) e = i;
          if (e < 0) begin
            put_result(KIND_FULL, id, 4'd0, 1'b0, 1'b1);
            return;
          end
          ent_valid[e] = 1; ent_slot[e] = id; ent_att[e] = 0;
        end
        ent_time[e] = add_sat(now, {28'd0, grace});
        ent_pend[e] = 1;
      end
      ACT_TICK: begin
        lim = int'(budget) > 16 ? 16 : int'(budget);
        for (int i = 0; i < 16; i++)
          due[i] = ent_valid[i] && ent_pend[i] && now >= ent_time[i];
        for (int i = 0; i < 16; i++) begin
          if (!due[i] || !enable) continue;
          while (ring_cnt > 0 &&
                 {1'b0, ring[ring_head]} + {17'd0, window} <= {1'b0, now}) begin
            ring_head = (ring_head + 1) % 16;
            ring_cnt--;
          end
          if (ring_cnt >= lim) begin
            ent_time[i] = add_sat(now, DenyDelayMs);
            trip = 1;
            continue;
          end
          ring[(ring_head + ring_cnt) % 16] = now;
          ring_cnt++;
          if (ent_att[i] < AttemptMax) ent_att[i]++;
          ent_pend[i] = 0;
          if (ent_att[i] > limit) begin
            ent_valid[i] = 0;
            put_result(KIND_GIVE_UP, ent_slot[i], ent_att[i], 1'b0, 1'b0);
          end else begin
            put_result(KIND_RESPAWN, ent_slot[i], ent_att[i], 1'b0, 1'b0);
          end
        end
        put_result(KIND_TICK_DONE, 32'd0, 4'd0, trip, 1'b1);
        return;
      end
      ACT_RETRY: if (e >= 0) begin
        if (imm) ent_time[e] = 0;
        ent_pend[e] = 1;
      end
      ACT_CANCEL: if (e >= 0) begin
        ent_valid[e] = 0; ent_pend[e] = 0; e = -1;
      end
      ACT_OUTCOME: if (e >= 0) begin
        if (ok) begin
          ent_valid[e] = 0; ent_pend[e] = 0; e = -1;
        end else begin
          dl = {28'd0, (ent_att[e] >= 3 ? back3 : (ent_att[e] == 2 ? back2 : back1))};
          ent_time[e] = add_sat(now, dl);
          ent_pend[e] = 1;
        end
      end
      default: ;
    endcase
    put_result(KIND_DONE, id, e >= 0 ? ent_att[e] : 4'd0, 1'b0, 1'b1);
  endtask

  assign pending_results = exp_wr - exp_rd;

  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      grace <= 1000; limit <= 3; back1 <= 1000; back2 <= 2000; back3 <= 4000;
      budget <= 8; window <= 10000; enable <= 1;
      for (int i = 0; i < 16; i++) begin
        ent_valid[i] = 0; ent_pend[i] = 0;
      end
      ring_head = 0; ring_cnt = 0;
      exp_wr = 0; exp_rd = 0;
      fail_count <= 0; result_total <= 0; respawn_total <= 0;
      giveup_total <= 0; trip_total <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_GRACE:  grace  <= cfg_data[19:0];
          REG_LIMIT:  limit  <= cfg_data[3:0];
          REG_BACK1:  back1  <= cfg_data[19:0];
          REG_BACK2:  back2  <= cfg_data[19:0];
          REG_BACK3:  back3  <= cfg_data[19:0];
          REG_BUDGET: budget <= cfg_data[4:0];
          REG_WINDOW: window <= cfg_data;
          REG_ENABLE: enable <= cfg_data[0];
          default: ;
        endcase
      end
      // outputs first: the result of a beat accepted now cannot appear this edge
      if (m_axis_tvalid && m_axis_tready) begin
        result_total <= result_total + 1;
        if (exp_wr == exp_rd) begin
          $error("result beat with nothing expected: kind %0d slot %0h",
                 m_axis_tuser, m_axis_tdata[31:0]);
          fail_count <= fail_count + 1;
        end else begin
          want = exp_mem[exp_rd % ExpDepth];
          exp_rd++;
          if (want.kind == KIND_RESPAWN) respawn_total <= respawn_total + 1;
          if (want.kind == KIND_GIVE_UP) giveup_total <= giveup_total + 1;
          if (want.trip) trip_total <= trip_total + 1;
          if (m_axis_tuser !== want.kind || m_axis_tdata[31:0] !== want.slot ||
              m_axis_tdata[35:32] !== want.att || m_axis_tdata[36] !== want.trip ||
              m_axis_tdata[41:37] !== want.cnt || m_axis_tlast !== want.last) begin
            fail_count <= fail_count + 1;
            if (m_axis_tuser !== want.kind)
              $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            if (m_axis_tdata[31:0] !== want.slot)
              $error("out_slot_id: expected %0h, got %0h", want.slot, m_axis_tdata[31:0]);
            if (m_axis_tdata[35:32] !== want.att)
              $error("attempt_number: expected %0d, got %0d", want.att,
                     m_axis_tdata[35:32]);
            if (m_axis_tdata[36] !== want.trip)
              $error("breaker_tripped: expected %0d, got %0d", want.trip,
                     m_axis_tdata[36]);
            if (m_axis_tdata[41:37] !== want.cnt)
              $error("entry_count: expected %0d, got %0d", want.cnt,
                     m_axis_tdata[41:37]);
            if (m_axis_tlast !== want.last)
              $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) schedule_step(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

// ----- tb/sv/crash_retry_scheduler_tb.sv -----
// testbench top for the crash retry scheduler: stimulus, stalls and verdict
`timescale 1ns / 1ps
module crash_retry_scheduler_tb import crs_pkg::*; ();

  localparam int WatchdogLimit = 20000;
  localparam int LongHoldCycles = 300;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending_results, result_total;
  int          respawn_total, giveup_total, trip_total;
  int          items_sent, idle_cycles;
  logic        long_hold, hold_served;
  logic [47:0] clock_ms;
  logic [31:0] slot_pool [8];

  crash_retry_scheduler dut (.*);

  crash_retry_scheduler_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off counted here when asked
  initial begin
    int hold_cycles;
    m_axis_tready = 0;
    hold_served = 0;
    @(negedge clk);
    forever begin
      if (long_hold && !hold_served) begin
        m_axis_tready <= 0;
        for (hold_cycles = 0; hold_cycles < LongHoldCycles; hold_cycles++)
          @(negedge clk);
        hold_served = 1;
      end else begin
        case ($urandom_range(0, 3))
          0: m_axis_tready <= 0;
          default: m_axis_tready <= 1;
        endcase
        @(negedge clk);
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout with %0d results outstanding", pending_results);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(action_t act, logic [31:0] id, logic [47:0] now,
                           logic imm, logic ok);
    s_axis_tdata  <= {6'd0, ok, imm, now, id};
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    // burst gaps
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_item();
    logic [31:0] id;
    int r;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? $urandom() : slot_pool[$urandom_range(0, 7)];
    clock_ms += 48'($urandom_range(0, 3000));
    if (r < 30)
      send_item(ACT_CRASH, id, clock_ms, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    else if (r < 62)
      send_item(ACT_TICK, $urandom(), clock_ms, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    else if (r < 72)
      send_item(ACT_RETRY, id, clock_ms, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    else if (r < 78)
      send_item(ACT_CANCEL, id, clock_ms, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    else if (r < 97)
      send_item(ACT_OUTCOME, id, clock_ms, 1'($urandom_range(0, 1)),
                $urandom_range(0, 3) == 0);
    else
      send_item(action_t'($urandom_range(5, 7)), id, clock_ms,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    cfg_valid = 0; cfg_index = REG_GRACE; cfg_data = '0;
    long_hold = 0; items_sent = 0;
    clock_ms = 48'd5000;
    for (int i = 0; i < 8; i++) slot_pool[i] = $urandom();
    slot_pool[0] = 32'd0; slot_pool[1] = 32'hFFFF_FFFF;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: default settings
    send_item(ACT_TICK, 32'd0, 48'd0, 1'b0, 1'b0);
    send_item(ACT_CRASH, 32'hFFFF_FFFF, 48'd0, 1'b1, 1'b1);
    send_item(ACT_CRASH, 32'd0, 48'd100, 1'b0, 1'b0);
    send_item(ACT_TICK, 32'd7, 48'd999, 1'b0, 1'b0);
    send_item(ACT_TICK, 32'd7, 48'd1100, 1'b0, 1'b0);
    send_item(ACT_OUTCOME, 32'd0, 48'd1200, 1'b0, 1'b0);
    send_item(ACT_RETRY, 32'hFFFF_FFFF, 48'd1300, 1'b1, 1'b0);
    send_item(ACT_RETRY, 32'h1234_5678, 48'd1300, 1'b1, 1'b0);
    send_item(ACT_CANCEL, 32'h1234_5678, 48'd1300, 1'b0, 1'b0);
    send_item(ACT_OUTCOME, 32'h1234_5678, 48'd1300, 1'b0, 1'b1);
    send_item(action_t'(3'd7), 32'd5, 48'd1300, 1'b1, 1'b1);
    send_item(ACT_CRASH, 32'd9, {48{1'b1}}, 1'b0, 1'b0);
    send_item(ACT_TICK, 32'd0, {48{1'b1}}, 1'b1, 1'b1);
    send_item(ACT_OUTCOME, 32'd9, {48{1'b1}}, 1'b0, 1'b1);
    send_item(ACT_CANCEL, 32'd0, {48{1'b1}}, 1'b0, 1'b0);
    drain();

    // table full, then flood ticks with budget 0 and the receiver held off
    write_reg(REG_GRACE, 32'd0);
    write_reg(REG_BUDGET, 32'd0);
    write_reg(REG_LIMIT, 32'd0);
    for (int i = 0; i < 17; i++) send_item(ACT_CRASH, 32'h100 + i, 48'd50, 1'b0, 1'b0);
    long_hold <= 1;
    repeat (4) send_item(ACT_TICK, 32'd0, 48'd60, 1'b0, 1'b0);
    long_hold <= 0;
    drain();
    write_reg(REG_BUDGET, 32'd31);
    send_item(ACT_TICK, 32'd0, 48'd5000, 1'b0, 1'b0);
    drain();

    // random phases across settings, extremes among them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_GRACE, 32'd500); write_reg(REG_LIMIT, 32'd3);
          write_reg(REG_BACK1, 32'd300); write_reg(REG_BACK2, 32'd900);
          write_reg(REG_BACK3, 32'd2500); write_reg(REG_BUDGET, 32'd3);
          write_reg(REG_WINDOW, 32'd4000); write_reg(REG_ENABLE, 32'd1);
        end
        1: begin
          write_reg(REG_LIMIT, 32'd15); write_reg(REG_BUDGET, 32'd16);
          write_reg(REG_WINDOW, 32'd1); write_reg(REG_BACK1, 32'd0);
          write_reg(REG_BACK2, 32'hF_FFFF); write_reg(REG_BACK3, 32'd0);
        end
        2: begin
          write_reg(REG_ENABLE, 32'd0); write_reg(REG_GRACE, 32'hF_FFFF);
          write_reg(REG_WINDOW, 32'hFFFF_FFFF); write_reg(REG_BUDGET, 32'd1);
          write_reg(REG_LIMIT, 32'd1);
        end
        default: begin
          write_reg(REG_ENABLE, 32'd1); write_reg(REG_GRACE, 32'd0);
          write_reg(REG_BUDGET, 32'd8); write_reg(REG_WINDOW, 32'd6000);
          write_reg(REG_LIMIT, 32'd2); write_reg(REG_BACK3, 32'd1500);
        end
      endcase
      for (int i = 0; i < 22; i++) random_item();
      if (phase == 1) clock_ms = {48{1'b1}} - 48'd20000;
      drain();
    end

    $display("items sent %0d, results %0d: %0d respawn, %0d give up, %0d tripped ticks",
             items_sent, result_total, respawn_total, giveup_total, trip_total);
    $display("covered table full, budget denial, saturation and four setting phases");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
